// ===== sv/wpm_pkg.sv =====
package wpm_pkg;

  typedef enum logic [1:0] {
    OP_PATTERN = 2'd0,
    OP_TEXT    = 2'd1,
    OP_END     = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_LIT = 2'd0,
    KIND_ONE = 2'd1,
    KIND_ANY = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_ESCAPE   = 2'd1,
    ERR_OVERFLOW = 2'd2
  } err_t;

  localparam logic REG_MATCH_MODE = 1'b0;
  localparam logic REG_ESCAPE     = 1'b1;

  localparam logic [15:0] CH_UNDERSCORE = 16'h005F;
  localparam logic [15:0] CH_PERCENT    = 16'h0025;
  localparam logic [15:0] CH_QUESTION   = 16'h003F;
  localparam logic [15:0] CH_STAR       = 16'h002A;

  // What one pattern character does to the pattern and escape state.
  typedef struct packed {
    logic  append;
    kind_t kind;
    logic  set_pending;
    logic  clr_pending;
    logic  raise_escape;
  } decode_t;

  typedef struct packed {
    logic matched;
    err_t error_code;
  } result_t;

endpackage

// ===== sv/wpm_in_if.sv =====
interface wpm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] symbol;

  modport source (output valid, output op, output symbol, input ready);
  modport sink (input valid, input op, input symbol, output ready);
endinterface

// ===== sv/wpm_out_if.sv =====
interface wpm_out_if;
  logic       valid;
  logic       ready;
  logic       matched;
  logic [1:0] error_code;

  modport source (output valid, output matched, output error_code, input ready);
  modport sink (input valid, input matched, input error_code, output ready);
endinterface

// ===== sv/wpm_decode.sv =====
module wpm_decode import wpm_pkg::*; (
  input  logic        match_mode,
  input  logic [15:0] escape_code,
  input  logic        pending,
  input  logic [15:0] symbol,
  output decode_t     dec
);

  always_comb begin
    dec.append       = 1'b0;
    dec.kind         = KIND_LIT;
    dec.set_pending  = 1'b0;
    dec.clr_pending  = 1'b0;
    dec.raise_escape = 1'b0;
    if (pending) begin
      // The character after an escape must be one that the escape can quote.
      dec.clr_pending = 1'b1;
      if (symbol == escape_code || symbol == CH_PERCENT || symbol == CH_UNDERSCORE) begin
        dec.append = 1'b1;
      end else begin
        dec.raise_escape = 1'b1;
      end
    end else if (!match_mode) begin
      if (escape_code != 16'd0 && symbol == escape_code) begin
        dec.set_pending = 1'b1;
      end else begin
        dec.append = 1'b1;
        if (symbol == CH_UNDERSCORE) begin
          dec.kind = KIND_ONE;
        end else if (symbol == CH_PERCENT) begin
          dec.kind = KIND_ANY;
        end
      end
    end else begin
      dec.append = 1'b1;
      if (symbol == CH_QUESTION) begin
        dec.kind = KIND_ONE;
      end else if (symbol == CH_STAR) begin
        dec.kind = KIND_ANY;
      end
    end
  end

endmodule

// ===== sv/wpm_engine.sv =====
module wpm_engine import wpm_pkg::*; #(
  parameter int PATTERN_MAX = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  op_t         op,
  input  logic [15:0] symbol,
  input  decode_t     dec,
  output logic        pending,
  output result_t     result
);

  localparam int NP = PATTERN_MAX + 1;
  localparam int LW = $clog2(PATTERN_MAX + 1);

  logic [15:0]   elem_char [PATTERN_MAX];
  kind_t         elem_kind [PATTERN_MAX];

  logic [LW-1:0] len, len_next;
  logic          pending_next;
  err_t          err, err_next;
  logic [NP-1:0] vec, vec_next;

  logic [NP-1:0] any_mask, step_vec, close_in, gen, closed, app_vec;
  logic          full, do_append;
  err_t          err_out;

  assign full      = (len == LW'(PATTERN_MAX));
  assign do_append = (op == OP_PATTERN) && dec.append && !full;

  always_comb begin
    any_mask = '0;
    step_vec = '0;
    app_vec  = vec;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (LW'(i) < len) begin
        any_mask[i] = (elem_kind[i] == KIND_ANY);
        if (vec[i]) begin
          if (elem_kind[i] == KIND_ANY) begin
            step_vec[i] = 1'b1;
          end else if (elem_kind[i] == KIND_ONE || elem_char[i] == symbol) begin
            step_vec[i+1] = 1'b1;
          end
        end
      end
      if (do_append && dec.kind == KIND_ANY && len == LW'(i) && vec[i]) begin
        app_vec[i+1] = 1'b1;
      end
    end
  end

  // Closure over runs of match-any elements: a set bit sitting on a match-any
  // element carries up through the run, so the carries of an add give every
  // position it reaches.
  assign close_in = (op == OP_TEXT) ? step_vec : NP'(1);
  assign gen      = close_in & any_mask;
  assign closed   = close_in | ((any_mask + gen) ^ any_mask ^ gen);

  always_comb begin
    err_out = err;
    if (err == ERR_NONE && pending) begin
      err_out = ERR_ESCAPE;
    end
    result.error_code = err_out;
    result.matched    = vec[len] && (err_out == ERR_NONE);
  end

  always_comb begin
    len_next     = len;
    pending_next = pending;
    err_next     = err;
    vec_next     = vec;
    case (op)
      OP_PATTERN: begin
        if (dec.set_pending) begin
          pending_next = 1'b1;
        end else if (dec.clr_pending) begin
          pending_next = 1'b0;
        end
        if (err == ERR_NONE && dec.raise_escape) begin
          err_next = ERR_ESCAPE;
        end else if (err == ERR_NONE && dec.append && full) begin
          err_next = ERR_OVERFLOW;
        end
        if (do_append) begin
          len_next = len + LW'(1);
        end
        vec_next = app_vec;
      end
      OP_TEXT: begin
        vec_next = closed;
      end
      OP_END: begin
        vec_next = closed;
      end
      OP_CLEAR: begin
        len_next     = '0;
        pending_next = 1'b0;
        err_next     = ERR_NONE;
        vec_next     = NP'(1);
      end
      default: begin
        vec_next = vec;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len     <= '0;
      pending <= 1'b0;
      err     <= ERR_NONE;
      vec     <= NP'(1);
    end else if (en) begin
      len     <= len_next;
      pending <= pending_next;
      err     <= err_next;
      vec     <= vec_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (en && do_append && len == LW'(i)) begin
        elem_kind[i] <= dec.kind;
        elem_char[i] <= symbol;
      end
    end
  end

`ifndef SYNTHESIS
  a_clear: assert property (@(posedge clk) disable iff (rst)
    en && op == OP_CLEAR |=> len == '0 && err == ERR_NONE && vec == NP'(1))
    else $error("pattern clear did not rearm the engine");

  a_err_held: assert property (@(posedge clk) disable iff (rst)
    err != ERR_NONE && !(en && op == OP_CLEAR) |=> $stable(err))
    else $error("held pattern error changed before a clear");

  a_vec_bound: assert property (@(posedge clk) disable iff (rst)
    (vec >> len) <= NP'(1))
    else $error("position vector has bits beyond the pattern end");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    en && op == OP_PATTERN && full |=> len == $past(len))
    else $error("pattern grew past its capacity");
`endif

endmodule

// ===== sv/wildcard_pattern_matcher.sv =====
// Wildcard pattern matcher (SQL LIKE with '_' and '%', or MATCHES with '?'
// and '*').
// Items arrive on the items channel: op 0 appends a pattern character, op 1
// streams a text character, op 2 ends the text and op 3 clears the pattern.
// Only an end-of-text item yields a transfer on the results channel, carrying
// matched and error_code; it also rearms the matcher for the next text while
// the pattern is kept.
// The configuration port writes match_mode (index 0) and escape_code
// (index 1); write them only while no item is in flight.
// Throughput is one item per cycle while the result channel is not stalled:
// the position vector over all pattern elements is updated together, with one
// carry chain closing runs of match-any elements. An end-of-text item passes
// through the input register; its result is held in the output register.
// While the receiver stalls, a waiting result holds in the output register;
// one more item is taken into the input register and then items.ready stays
// low until the result has gone.
// Reset empties the pattern, clears the errors and the configuration, and
// leaves the block ready at once; no clearing pass is needed.
module wildcard_pattern_matcher import wpm_pkg::*; #(
  parameter int PATTERN_MAX = 32
) (
  input  logic        clk,
  input  logic        rst,
  wpm_in_if.sink      items,
  wpm_out_if.source   results,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic        match_mode;
  logic [15:0] escape_code;

  logic        s_valid;
  op_t         s_op;
  logic [15:0] s_symbol;
  logic        advance;

  logic        o_valid;
  result_t     o_result;

  logic        pending;
  decode_t     dec;
  result_t     result;

  assign advance     = s_valid && (!o_valid || results.ready);
  assign items.ready = !s_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_mode  <= 1'b0;
      escape_code <= 16'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MATCH_MODE: match_mode  <= cfg_data[0];
        REG_ESCAPE:     escape_code <= cfg_data;
        default:        match_mode  <= match_mode;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (items.ready) begin
      s_valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      s_op     <= op_t'(items.op);
      s_symbol <= items.symbol;
    end
  end

  wpm_decode u_decode (
    .match_mode  (match_mode),
    .escape_code (escape_code),
    .pending     (pending),
    .symbol      (s_symbol),
    .dec         (dec)
  );

  wpm_engine #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_engine (
    .clk     (clk),
    .rst     (rst),
    .en      (advance),
    .op      (s_op),
    .symbol  (s_symbol),
    .dec     (dec),
    .pending (pending),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (advance && s_op == OP_END) begin
      o_valid <= 1'b1;
    end else if (results.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s_op == OP_END) begin
      o_result <= result;
    end
  end

  assign results.valid      = o_valid;
  assign results.matched    = o_result.matched;
  assign results.error_code = o_result.error_code;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    o_valid && !results.ready |-> !advance)
    else $error("stalled result would be overwritten");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(o_valid) |-> $past(s_valid) && $past(s_op) == OP_END)
    else $error("result raised without an end-of-text item");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    o_valid && !results.ready |=> o_valid && $stable(o_result))
    else $error("stalled result changed before its transfer");
`endif

endmodule
